// File: src/mtbi_pkg.sv
// Shared field widths for the barycentric-to-microtriangle index block.
`timescale 1ns / 1ps

package mtbi_pkg;

    localparam int COORD_W = 17;
    localparam int LEVEL_W = 4;
    localparam int INDEX_W = 24;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [INDEX_W-1:0] index_t;

endpackage

// File: src/microtriangle_bary_to_index.sv
// Barycentric point and level to curve-order microtriangle index, four-stage pipeline.
`timescale 1ns / 1ps

// Takes one query per cycle unless a valid output is stalled, and has four register
// stages (saturate and clamp, cell and fraction carry, fold and curve bits, prefix XOR
// and interleave). A stall on a valid output freezes the whole pipeline, and the input
// stall follows it in the same cycle. Coordinates above 1.0 saturate to 1.0, levels
// above MAX_LEVEL or FRAC_BITS saturate to that bound, and level zero gives index zero.
module microtriangle_bary_to_index #(
    parameter int MAX_LEVEL = 12,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mtbi_pkg::coord_t    u_coord,
    input  mtbi_pkg::coord_t    v_coord,
    input  mtbi_pkg::level_t    level,
    output logic                out_valid,
    input  logic                out_stall,
    output mtbi_pkg::index_t    micro_index
);

    localparam int CW      = (FRAC_BITS + 1 > mtbi_pkg::COORD_W) ? FRAC_BITS + 1
                                                                 : mtbi_pkg::COORD_W;
    localparam int NB      = MAX_LEVEL;
    localparam int LVL_CAP = (MAX_LEVEL < FRAC_BITS) ? MAX_LEVEL : FRAC_BITS;
    localparam int LVW     = $clog2(MAX_LEVEL + 1);
    localparam int SHW     = $clog2(FRAC_BITS + 1);
    localparam int IXW     = 2 * NB;
    localparam int IXW2    = (IXW > mtbi_pkg::INDEX_W) ? IXW : mtbi_pkg::INDEX_W;

    localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    logic adv;

    // stage 1
    logic            v1_reg, v1_next;
    logic [CW-1:0]   u1_reg, u1_next;
    logic [CW-1:0]   w1_reg, w1_next;
    logic [LVW-1:0]  lvl1_reg, lvl1_next;
    logic [SHW-1:0]  sh1_reg, sh1_next;

    // stage 2
    logic            v2_reg, v2_next;
    logic [NB-1:0]   iu2_reg, iu2_next;
    logic [NB-1:0]   iv2_reg, iv2_next;
    logic [NB:0]     across2_reg, across2_next;
    logic            carry2_reg, carry2_next;

    // stage 3
    logic            v3_reg, v3_next;
    logic [NB-1:0]   iu3_reg, iu3_next;
    logic [NB-1:0]   b03_reg, b03_next;
    logic [NB-1:0]   t3_reg, t3_next;
    logic [NB-1:0]   amask3_reg, amask3_next;

    // stage 4
    logic                   v4_reg, v4_next;
    mtbi_pkg::index_t       idx4_reg, idx4_next;

    assign adv       = !(v4_reg && out_stall);
    assign in_stall  = !adv;
    assign out_valid = v4_reg;
    assign micro_index = idx4_reg;

    always_comb
    begin
        logic [CW-1:0] ue;
        logic [CW-1:0] ve;
        ue = CW'(u_coord);
        ve = CW'(v_coord);
        v1_next = in_valid;
        u1_next = (ue > ONE) ? ONE : ue;
        w1_next = (ve > ONE) ? ONE : ve;
        if (int'(level) > LVL_CAP)
        begin
            lvl1_next = LVW'(LVL_CAP);
        end
        else
        begin
            lvl1_next = LVW'(level);
        end
        sh1_next = SHW'(FRAC_BITS) - SHW'(lvl1_next);
    end

    always_comb
    begin
        logic [CW-1:0] us;
        logic [CW-1:0] vs;
        logic [CW-1:0] fmask;
        logic [CW:0]   fsum;
        logic [NB:0]   acr;
        acr   = (NB + 1)'(1) << lvl1_reg;
        us    = u1_reg >> sh1_reg;
        vs    = w1_reg >> sh1_reg;
        fmask = (CW'(1) << sh1_reg) - CW'(1);
        fsum  = {1'b0, u1_reg & fmask} + {1'b0, w1_reg & fmask};
        v2_next      = v1_reg;
        across2_next = acr;
        iu2_next     = (us >= CW'(acr)) ? NB'(acr - (NB + 1)'(1)) : NB'(us);
        iv2_next     = (vs >= CW'(acr)) ? NB'(acr - (NB + 1)'(1)) : NB'(vs);
        carry2_next  = fsum >= ((CW + 1)'(1) << sh1_reg);
    end

    always_comb
    begin
        logic [NB:0]   sum;
        logic [NB-1:0] iuf;
        logic [NB-1:0] iw;
        logic [NB-1:0] am;
        sum = {1'b0, iu2_reg} + {1'b0, iv2_reg};
        am  = NB'(across2_reg - (NB + 1)'(1));
        if (sum >= across2_reg)
        begin
            iuf = am - iv2_reg;
        end
        else
        begin
            iuf = iu2_reg;
        end
        iw = ~(iuf + iv2_reg);
        if (carry2_reg && (sum + (NB + 1)'(1) < across2_reg))
        begin
            iw = iw - NB'(1);
        end
        v3_next     = v2_reg;
        iu3_next    = iuf;
        amask3_next = am;
        b03_next    = ~(iuf ^ iw) & am;
        t3_next     = (iuf ^ iv2_reg) & b03_next;
    end

    always_comb
    begin
        logic [NB-1:0]   f;
        logic [NB-1:0]   b1;
        logic [IXW2-1:0] wide;
        f  = t3_reg;
        f  = f ^ (f >> 1);
        f  = f ^ (f >> 2);
        f  = f ^ (f >> 4);
        f  = f ^ (f >> 8);
        b1 = (((f ^ iu3_reg) & ~b03_reg) | t3_reg) & amask3_reg;
        wide = '0;
        for (int i = 0; i < NB; i++)
        begin
            wide[2*i]   = b03_reg[i];
            wide[2*i+1] = b1[i];
        end
        v4_next   = v3_reg;
        idx4_next = wide[mtbi_pkg::INDEX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u1_reg      <= u1_next;
            w1_reg      <= w1_next;
            lvl1_reg    <= lvl1_next;
            sh1_reg     <= sh1_next;
            iu2_reg     <= iu2_next;
            iv2_reg     <= iv2_next;
            across2_reg <= across2_next;
            carry2_reg  <= carry2_next;
            iu3_reg     <= iu3_next;
            b03_reg     <= b03_next;
            t3_reg      <= t3_next;
            amask3_reg  <= amask3_next;
            idx4_reg    <= idx4_next;
        end
    end

`ifndef SYNTHESIS
    a_cell_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> ({1'b0, iu2_reg} < across2_reg) && ({1'b0, iv2_reg} < across2_reg))
        else $error("cell coordinate past the row width");

    a_curve_bits_masked: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> ((b03_reg & ~amask3_reg) == '0) && ((t3_reg & ~b03_reg) == '0))
        else $error("curve bits outside the level mask");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && out_stall) |=> $stable(v3_reg) && $stable(v2_reg) && $stable(v1_reg))
        else $error("pipeline moved while the output was stalled");

    a_index_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((IXW2'(micro_index) >> IXW) == '0))
        else $error("index bits above the deepest level");
`endif

endmodule
